// ===== src/slm_pkg.sv =====
// Shared types and codes for the sorted list merge block.
package slm_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ModeW  = 2;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [ModeW-1:0]  mode_t;

  // Transaction kinds carried on the input tuser.
  localparam mode_t ModeAppendA = 2'd0;
  localparam mode_t ModeAppendB = 2'd1;
  localparam mode_t ModeMerge   = 2'd2;

endpackage

// ===== src/slm_list.sv =====
// One list store: element memory with registered read port and fill count.
module slm_list #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                append_i,
  input  slm_pkg::value_t     append_data_i,
  input  logic                clear_i,
  input  logic [CntW-1:0]     rd_ptr_i,
  output slm_pkg::value_t     rd_data_o,
  output logic [CntW-1:0]     count_o
);
  import slm_pkg::*;

  value_t            mem [DEPTH];
  value_t            rd_data_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              full;
  logic              wr_en;

  assign full  = (count_q == CntW'(DEPTH));
  assign wr_en = append_i && !full;

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // write at the fill count, read at the merge pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AddrW-1:0]] <= append_data_i;
    end
    rd_data_q <= mem[rd_ptr_i[AddrW-1:0]];
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

// ===== src/sorted_list_merge_top.sv =====
// Top level of the sorted list merge block: two list stores and the merge sequencer.
//
// Two-way merge of two ascending lists of signed 32-bit values. Each input
// transaction carries a kind on tuser: append to the first list, append to the
// second list, or merge (kind 3 is dropped). Appends are taken while the input
// is ready and are silently dropped once a list holds LIST_DEPTH elements. A
// merge emits every stored element in ascending order, one output transaction
// per element, tlast on the final one, then empties both lists; merging two
// empty lists emits nothing. On equal heads the second list's element goes out
// first. Each element passes through StRead, the registered read of the list
// memories, then StEmit, one pass of the single shared signed comparator, which
// waits on output backpressure. The input is not ready while a merge is in
// progress. A finished result sits in an output register, so new appends are
// taken while the last result waits to be consumed.
module sorted_list_merge_top #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  slm_pkg::value_t     s_axis_tdata_i,   // [31:0] value
  input  slm_pkg::mode_t      s_axis_tuser_i,   // [1:0] mode
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output slm_pkg::value_t     m_axis_tdata_o,   // [31:0] value_res
  output logic                m_axis_tlast_o
);
  import slm_pkg::*;

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned RemW = CntW + 1;

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;  // memories fetch the heads
  localparam logic [1:0] StEmit = 2'd2;  // compare heads, push one result

  logic [1:0]      st_q, st_d;
  logic [CntW-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_a, cnt_b;
  value_t          head_a, head_b;

  logic            in_fire;
  logic            app_a, app_b, merge_req;
  logic            out_free, out_load;
  logic            take_a;
  logic            done;
  logic [RemW-1:0] total;

  logic            out_valid_q, out_valid_d;
  value_t          out_data_q, out_data_d;
  logic            out_last_q, out_last_d;

  assign s_axis_tready_o = (st_q == StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    app_a     = 1'b0;
    app_b     = 1'b0;
    merge_req = 1'b0;
    case (s_axis_tuser_i)
      ModeAppendA: app_a     = in_fire;
      ModeAppendB: app_b     = in_fire;
      ModeMerge:   merge_req = in_fire;
      default: ;
    endcase
  end

  assign total = {1'b0, cnt_a} + {1'b0, cnt_b};

  // shared unit: a single signed compare of the two heads
  assign take_a = (ptr_a_q < cnt_a) &&
                  ((ptr_b_q >= cnt_b) || ($signed(head_a) < $signed(head_b)));

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign out_load = (st_q == StEmit) && out_free;
  assign done     = out_load && (rem_q == RemW'(1));

  always_comb begin
    st_d    = st_q;
    ptr_a_d = ptr_a_q;
    ptr_b_d = ptr_b_q;
    rem_d   = rem_q;
    case (st_q)
      StIdle: begin
        if (merge_req && (total != '0)) begin
          rem_d = total;
          st_d  = StRead;
        end
      end
      StRead: begin
        st_d = StEmit;
      end
      StEmit: begin
        if (out_load) begin
          rem_d = rem_q - RemW'(1);
          if (take_a) begin
            ptr_a_d = ptr_a_q + CntW'(1);
          end else begin
            ptr_b_d = ptr_b_q + CntW'(1);
          end
          if (done) begin
            ptr_a_d = '0;
            ptr_b_d = '0;
            st_d    = StIdle;
          end else begin
            st_d = StRead;
          end
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = take_a ? head_a : head_b;
      out_last_d  = (rem_q == RemW'(1));
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      ptr_a_q     <= '0;
      ptr_b_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ptr_a_q     <= ptr_a_d;
      ptr_b_q     <= ptr_b_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  slm_list #(
    .DEPTH(LIST_DEPTH)
  ) u_list_a (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .append_i      (app_a),
    .append_data_i (s_axis_tdata_i),
    .clear_i       (done),
    .rd_ptr_i      (ptr_a_q),
    .rd_data_o     (head_a),
    .count_o       (cnt_a)
  );

  slm_list #(
    .DEPTH(LIST_DEPTH)
  ) u_list_b (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .append_i      (app_b),
    .append_data_i (s_axis_tdata_i),
    .clear_i       (done),
    .rd_ptr_i      (ptr_b_q),
    .rd_data_o     (head_b),
    .count_o       (cnt_b)
  );

`ifndef NO_ASSERTIONS
  // merge pointers never run past the stored counts
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> ((ptr_a_q <= cnt_a) && (ptr_b_q <= cnt_b)))
    else $error("merge pointer past list count");

  // remaining count tracks the elements not yet consumed
  a_rem_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |->
      (rem_q == (total - {1'b0, ptr_a_q} - {1'b0, ptr_b_q})))
    else $error("remaining count out of step with pointers");

  // the final result empties both lists
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> ((cnt_a == '0) && (cnt_b == '0) && (st_q == StIdle)))
    else $error("lists not cleared after last result");

  // a result loaded with tlast leaves no work behind
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (rem_q == RemW'(1))) |=> (m_axis_tlast_o && (rem_q == '0)))
    else $error("tlast without finishing the merge");
`endif

endmodule
